>>> rtl/rwtm_pkg.sv
// Shared widths, command codes and divider status type for the wall texel mapper.
`timescale 1ns / 1ps

package rwtm_pkg;

   // Command codes carried in req_tuser
   localparam logic CMD_COLUMN = 1'b0;
   localparam logic CMD_ROW    = 1'b1;

   // Texture facings
   localparam logic [1:0] TEX_EAST  = 2'd0;
   localparam logic [1:0] TEX_WEST  = 2'd1;
   localparam logic [1:0] TEX_SOUTH = 2'd2;
   localparam logic [1:0] TEX_NORTH = 2'd3;

   // Field widths
   localparam int SIZE_W = 11;                 // texture width/height register
   localparam int LH_W   = 15;                 // line height
   localparam int DEN_W  = LH_W + 8;           // line height * 256
   localparam int QUO_W  = SIZE_W;             // quotient bits kept before the clamp
   localparam int NUM_W  = DEN_W + QUO_W;      // d * height

   typedef struct packed {
      logic done;
      logic ovf;
   } div_status_type;

endpackage

>>> rtl/rwtm_div.sv
// Restoring divider, one quotient bit per cycle, with quotient overflow flag.
`timescale 1ns / 1ps

module rwtm_div
   import rwtm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_W-1:0]     num,
   input  logic [DEN_W-1:0]     den,
   output div_status_type       stat,
   output logic [QUO_W-1:0]     quo
);

   localparam int CNT_W = $clog2(QUO_W + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 ovf_ff, ovf_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DEN_W:0]       rem_ff, rem_in;
   logic [QUO_W-1:0]     lo_ff, lo_in;

   logic [DEN_W:0]       trial;
   logic                 fits;

   assign trial = {rem_ff[DEN_W-1:0], lo_ff[QUO_W-1]};
   assign fits  = trial >= {1'b0, den};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      if (start) begin
         // quotient would not fit in QUO_W bits: flag it and skip the steps
         if (num >= {den, {QUO_W{1'b0}}}) begin
            ovf_in  = 1'b1;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            ovf_in  = 1'b0;
            busy_in = 1'b1;
            cnt_in  = CNT_W'(QUO_W);
            rem_in  = {1'b0, num[NUM_W-1:QUO_W]};
            lo_in   = num[QUO_W-1:0];
         end
      end else if (busy_ff) begin
         rem_in = fits ? (trial - {1'b0, den}) : trial;
         lo_in  = {lo_ff[QUO_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         ovf_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         ovf_ff  <= ovf_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
   end

   assign stat.done = done_ff;
   assign stat.ovf  = ovf_ff;
   assign quo       = lo_ff;

endmodule

>>> rtl/raycast_wall_texel_mapper.sv
// Raycaster wall texel mapper: column setup and per-row texel address generation.
`timescale 1ns / 1ps

// A column item (req_tuser = 0) picks the wall texture, works out the texture
// column and stores it with the line height, end row and screen column; it
// gives no result; the block takes the next item after ST_COL_MUL, ST_COL_FRAC
// and ST_COL_DONE. A row item (req_tuser = 1) gives one result with the
// texture row, texel byte offset and screen coordinates. It passes ST_ROW_MUL,
// ST_ROW_GO, ST_ROW_DIV (the 11-step restoring divider, whose steps are skipped
// on quotient overflow), ST_ROW_OFF and ST_ROW_OUT; rows at or above the start
// of the texture skip the division. The block takes the next item in the cycle
// after the result is loaded. All products go through one shared 25x18
// multiplier with a registered output. req_tready is high only while no item
// is in flight. The result sits in an output register, so the block returns
// to idle as soon as that register is free; a stalled result holds the block
// in its last state. Texture sizes are written over the csr port, which is
// always ready; write them only while the block is idle.
module raycast_wall_texel_mapper
   import rwtm_pkg::*;
#(
   parameter int SCREEN_HEIGHT = 512,
   parameter int MAX_TEX_SIZE  = 1024
) (
   input  logic         clock,
   input  logic         reset,
   // hit_side[0], dir_x[18:1], dir_y[36:19], viewer_x[60:37], viewer_y[84:61],
   // wall_distance[108:85], line_height[123:109], end_row[133:124],
   // column_x[143:134], row_y[152:144], zero[159:153]
   input  logic [159:0] req_tdata,
   input  logic         req_tuser,  // cmd[0]
   input  logic         req_tvalid,
   output logic         req_tready,
   // texture_id[1:0], texel_col[11:2], texel_row[21:12], texel_offset[43:22],
   // screen_x[53:44], screen_y[62:54], zero[63]
   output logic [63:0]  rsp_tdata,
   output logic         rsp_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [10:0]  csr_data
);

   localparam logic [12:0] MAX_SIZE   = 13'(MAX_TEX_SIZE);
   localparam logic [23:0] ROW_CENTER = 24'(SCREEN_HEIGHT * 128);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_COL_MUL  = 4'd1;
   localparam logic [3:0] ST_COL_FRAC = 4'd2;
   localparam logic [3:0] ST_COL_DONE = 4'd3;
   localparam logic [3:0] ST_ROW_MUL  = 4'd4;
   localparam logic [3:0] ST_ROW_GO   = 4'd5;
   localparam logic [3:0] ST_ROW_DIV  = 4'd6;
   localparam logic [3:0] ST_ROW_OFF  = 4'd7;
   localparam logic [3:0] ST_ROW_OUT  = 4'd8;

   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
      logic [SIZE_W-1:0] r;
      if (v == '0)
         r = SIZE_W'(1);
      else if ({2'b00, v} > MAX_SIZE)
         r = MAX_SIZE[SIZE_W-1:0];
      else
         r = v;
      return r;
   endfunction

   // input fields
   logic               in_side;
   logic signed [17:0] in_dir_x, in_dir_y;
   logic [23:0]        in_view_x, in_view_y, in_dist;
   logic [LH_W-1:0]    in_lh;
   logic [9:0]         in_end_row, in_column;
   logic [8:0]         in_row_y;

   assign in_side    = req_tdata[0];
   assign in_dir_x   = req_tdata[18:1];
   assign in_dir_y   = req_tdata[36:19];
   assign in_view_x  = req_tdata[60:37];
   assign in_view_y  = req_tdata[84:61];
   assign in_dist    = req_tdata[108:85];
   assign in_lh      = req_tdata[123:109];
   assign in_end_row = req_tdata[133:124];
   assign in_column  = req_tdata[143:134];
   assign in_row_y   = req_tdata[152:144];

   logic [3:0]          state_ff, state_in;
   logic [SIZE_W-1:0]   width_ff  [4];
   logic [SIZE_W-1:0]   height_ff [4];

   logic [1:0]          cur_tex_ff;
   logic [9:0]          cur_texel_col_ff;
   logic [LH_W-1:0]     cur_lh_ff;
   logic [9:0]          cur_end_ff;
   logic [9:0]          cur_column_ff;

   logic [23:0]         dist_ff;
   logic signed [17:0]  dir_ff;
   logic [15:0]         view_frac_ff;
   logic                mirror_ff;
   logic signed [23:0]  d_ff;
   logic [8:0]          y_ff;
   logic [9:0]          row_ff;
   logic signed [42:0]  prod_ff;

   logic                rsp_valid_ff;
   logic [63:0]         rsp_data_ff;
   logic                rsp_last_ff;

   logic                accept;
   logic [1:0]          tex_sel;
   logic                mirror_sel;
   logic [SIZE_W-1:0]   w_eff, h_eff, h_max;
   logic signed [24:0]  mul_a;
   logic signed [17:0]  mul_b;
   logic [15:0]         frac;
   logic [SIZE_W-1:0]   col_raw, col_fix;
   logic                d_pos;
   logic                out_load;
   logic [19:0]         ofs_sum;
   logic                row_last;
   logic [SIZE_W-1:0]   row_clamp;

   div_status_type      div_stat;
   logic [QUO_W-1:0]    div_quo;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;

   // texture choice and mirroring from hit side and direction signs
   always_comb begin
      if (!in_side && !in_dir_x[17] && in_dir_x != '0)
         tex_sel = TEX_EAST;
      else if (!in_side && in_dir_x[17])
         tex_sel = TEX_WEST;
      else if (in_side && !in_dir_y[17] && in_dir_y != '0)
         tex_sel = TEX_SOUTH;
      else
         tex_sel = TEX_NORTH;
   end

   assign mirror_sel = (tex_sel == TEX_EAST) || (in_side && in_dir_y[17]);

   assign w_eff = eff_size(width_ff[cur_tex_ff]);
   assign h_eff = eff_size(height_ff[cur_tex_ff]);
   assign h_max = h_eff - SIZE_W'(1);

   assign frac    = view_frac_ff + prod_ff[31:16];
   assign col_raw = prod_ff[26:16];
   assign col_fix = mirror_ff ? (w_eff - col_raw - SIZE_W'(1)) : col_raw;
   assign d_pos   = !d_ff[23] && (d_ff != '0);

   // shared multiplier operand select
   always_comb begin
      case (state_ff)
         ST_COL_MUL: begin
            mul_a = $signed({1'b0, dist_ff});
            mul_b = dir_ff;
         end
         ST_COL_FRAC: begin
            mul_a = $signed({9'b0, frac});
            mul_b = $signed({7'b0, w_eff});
         end
         ST_ROW_MUL: begin
            mul_a = $signed({2'b0, d_ff[22:0]});
            mul_b = $signed({7'b0, h_eff});
         end
         ST_ROW_OFF: begin
            mul_a = $signed({15'b0, row_ff});
            mul_b = $signed({7'b0, w_eff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   rwtm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (state_ff == ST_ROW_GO),
      .num   (prod_ff[NUM_W-1:0]),
      .den   ({cur_lh_ff, 8'b0}),
      .stat  (div_stat),
      .quo   (div_quo)
   );

   assign row_clamp = (div_stat.ovf || div_quo > h_max) ? h_max : div_quo;

   assign out_load = (state_ff == ST_ROW_OUT) && (!rsp_valid_ff || rsp_tready);
   assign ofs_sum  = prod_ff[19:0] + {10'b0, cur_texel_col_ff};
   assign row_last = (cur_end_ff != '0) && ({1'b0, y_ff} + 10'd1 == cur_end_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:
            if (accept)
               state_in = (req_tuser == CMD_COLUMN) ? ST_COL_MUL : ST_ROW_MUL;
         ST_COL_MUL:  state_in = ST_COL_FRAC;
         ST_COL_FRAC: state_in = ST_COL_DONE;
         ST_COL_DONE: state_in = ST_IDLE;
         ST_ROW_MUL:  state_in = d_pos ? ST_ROW_GO : ST_ROW_OFF;
         ST_ROW_GO:   state_in = ST_ROW_DIV;
         ST_ROW_DIV:
            if (div_stat.done)
               state_in = ST_ROW_OFF;
         ST_ROW_OFF:  state_in = ST_ROW_OUT;
         ST_ROW_OUT:
            if (out_load)
               state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         cur_tex_ff       <= TEX_EAST;
         cur_texel_col_ff <= '0;
         cur_lh_ff        <= LH_W'(1);
         cur_end_ff       <= '0;
         cur_column_ff    <= '0;
         for (int i = 0; i < 4; i++) begin
            width_ff[i]  <= SIZE_W'(64);
            height_ff[i] <= SIZE_W'(64);
         end
      end else begin
         state_ff <= state_in;
         if (out_load)
            rsp_valid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_valid_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            if (!csr_index[0])
               width_ff[csr_index[2:1]] <= csr_data;
            else
               height_ff[csr_index[2:1]] <= csr_data;
         end
         if (accept && req_tuser == CMD_COLUMN) begin
            cur_tex_ff    <= tex_sel;
            cur_lh_ff     <= (in_lh == '0) ? LH_W'(1) : in_lh;
            cur_end_ff    <= in_end_row;
            cur_column_ff <= in_column;
         end
         if (state_ff == ST_COL_DONE)
            cur_texel_col_ff <= col_fix[9:0];
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         dist_ff      <= in_dist;
         dir_ff       <= in_side ? in_dir_x : in_dir_y;
         view_frac_ff <= in_side ? in_view_x[15:0] : in_view_y[15:0];
         mirror_ff    <= mirror_sel;
         y_ff         <= in_row_y;
         d_ff         <= $signed({7'b0, in_row_y, 8'b0}
                                 + {2'b0, cur_lh_ff, 7'b0} - ROW_CENTER);
      end
      if (state_ff == ST_ROW_MUL && !d_pos)
         row_ff <= '0;
      else if (state_ff == ST_ROW_DIV && div_stat.done)
         row_ff <= row_clamp[9:0];
      if (out_load) begin
         rsp_data_ff <= {1'b0, y_ff, cur_column_ff, ofs_sum, 2'b00, row_ff,
                         cur_texel_col_ff, cur_tex_ff};
         rsp_last_ff <= row_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> rtl/rwtm_checker.sv
// Port-level checks for the wall texel mapper, bound to the top level.
`timescale 1ns / 1ps

module rwtm_checker
   import rwtm_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_tuser,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [63:0]  rsp_tdata,
   input logic         rsp_tlast,
   input logic         rsp_tvalid,
   input logic         rsp_tready
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // the block is busy the cycle after any accepted item
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after an accepted item");

   // a column item never raises a result
   a_col_quiet: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == CMD_COLUMN |=> !$rose(rsp_tvalid))
      else $error("result after column item");

   // byte offset is word aligned and the pad bit is zero
   a_align: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:22] == 2'b00 && !rsp_tdata[63])
      else $error("misaligned texel offset");

endmodule

bind raycast_wall_texel_mapper rwtm_checker u_rwtm_checker (.*);

>>> sim/tb_raycast_wall_texel_mapper.sv
// Self-checking testbench for the raycaster wall texel mapper.
`timescale 1ns / 1ps

module tb_raycast_wall_texel_mapper
   import rwtm_pkg::*;
();

   localparam int SCREEN_H     = 512;
   localparam int MAX_TEX      = 1024;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 140;
   localparam int SETTLE_CYC   = 40;

   typedef struct packed {
      logic        cmd;
      logic        side;
      logic [17:0] dir_x;
      logic [17:0] dir_y;
      logic [23:0] viewer_x;
      logic [23:0] viewer_y;
      logic [23:0] wall_dist;
      logic [14:0] line_height;
      logic [9:0]  end_row;
      logic [9:0]  column_x;
      logic [8:0]  row_y;
   } wall_item_t;

   typedef struct packed {
      logic [1:0]  texture_id;
      logic [9:0]  texel_col;
      logic [9:0]  texel_row;
      logic [21:0] texel_offset;
      logic [9:0]  screen_x;
      logic [8:0]  screen_y;
      logic        last;
   } texel_t;

   // Tracks texture sizes and the stored column, predicts one texel per row item
   class texel_scoreboard;
      logic [10:0] sizes[8];
      logic [1:0]  cur_tex;
      logic [9:0]  cur_col;
      logic [14:0] cur_lh;
      logic [9:0]  cur_end;
      logic [9:0]  cur_x;
      texel_t      expected_texels[$];
      int          columns;
      int          rows;
      int          checked;
      int          mismatches;

      function new();
         foreach (sizes[i]) sizes[i] = 11'd64;
         cur_tex = TEX_EAST;
         cur_col = '0;
         cur_lh = 15'd1;
         cur_end = '0;
         cur_x = '0;
      endfunction

      function void write_size(logic [2:0] idx, logic [10:0] value);
         sizes[idx] = value;
      endfunction

      // clamp a size register to the usable texture range
      function longint usable(logic [10:0] v);
         if (v == 0) return 1;
         if (v > MAX_TEX) return MAX_TEX;
         return longint'(v);
      endfunction

      function void log_request(wall_item_t it);
         longint     dx, dy, hit, w, h, col, span, row, ofs;
         logic [1:0] tex;
         logic [15:0] frac;
         texel_t     want;
         dx = $signed(it.dir_x);
         dy = $signed(it.dir_y);
         if (it.cmd == CMD_COLUMN) begin
            columns++;
            if (it.side == 1'b0 && dx > 0) tex = TEX_EAST;
            else if (it.side == 1'b0 && dx < 0) tex = TEX_WEST;
            else if (it.side == 1'b1 && dy > 0) tex = TEX_SOUTH;
            else tex = TEX_NORTH;
            w = usable(sizes[{tex, 1'b0}]);
            if (it.side == 1'b0)
               hit = (longint'(it.viewer_y) << 16) + longint'(it.wall_dist) * dy;
            else
               hit = (longint'(it.viewer_x) << 16) + longint'(it.wall_dist) * dx;
            // bits 31:16 floor toward minus infinity, negative sums included
            frac = hit[31:16];
            col = (longint'(frac) * w) >> 16;
            if ((it.side == 1'b0 && dx > 0) || (it.side == 1'b1 && dy < 0))
               col = w - col - 1;
            cur_tex = tex;
            cur_col = col[9:0];
            cur_lh = (it.line_height == 0) ? 15'd1 : it.line_height;
            cur_end = it.end_row;
            cur_x = it.column_x;
         end else begin
            rows++;
            w = usable(sizes[{cur_tex, 1'b0}]);
            h = usable(sizes[{cur_tex, 1'b1}]);
            span = longint'(it.row_y) * 256 - SCREEN_H * 128 + longint'(cur_lh) * 128;
            row = 0;
            if (span > 0) begin
               row = span * h / longint'(cur_lh) / 256;
               if (row > h - 1) row = h - 1;
            end
            row = row & 64'h3FF;
            ofs = (row * w + longint'(cur_col)) * 4;
            want.texture_id   = cur_tex;
            want.texel_col    = cur_col;
            want.texel_row    = row[9:0];
            want.texel_offset = ofs[21:0];
            want.screen_x     = cur_x;
            want.screen_y     = it.row_y;
            want.last         = (cur_end != 0) && (int'(it.row_y) + 1 == int'(cur_end));
            expected_texels.push_back(want);
         end
      endfunction

      function void check_texel(logic [63:0] d, logic tl);
         texel_t got, want;
         got.texture_id   = d[1:0];
         got.texel_col    = d[11:2];
         got.texel_row    = d[21:12];
         got.texel_offset = d[43:22];
         got.screen_x     = d[53:44];
         got.screen_y     = d[62:54];
         got.last         = tl;
         checked++;
         if (expected_texels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] unexpected texel result tdata=%h last=%b", $realtime, d, tl);
            return;
         end
         want = expected_texels.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("[%0t] texel mismatch on result %0d", $realtime, checked);
               $display("   expected tex=%0d col=%0d row=%0d off=%0d x=%0d y=%0d last=%b",
                        want.texture_id, want.texel_col, want.texel_row,
                        want.texel_offset, want.screen_x, want.screen_y, want.last);
               $display("   actual   tex=%0d col=%0d row=%0d off=%0d x=%0d y=%0d last=%b",
                        got.texture_id, got.texel_col, got.texel_row,
                        got.texel_offset, got.screen_x, got.screen_y, got.last);
            end
         end
      endfunction

      function int pending();
         return expected_texels.size();
      endfunction
   endclass

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic [159:0] req_tdata  = '0;
   logic         req_tuser  = CMD_COLUMN;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [63:0]  rsp_tdata;
   logic         rsp_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic         csr_valid  = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index  = '0;
   logic [10:0]  csr_data   = '0;

   texel_scoreboard sb;
   int gap_pct    = 0;
   int stall_pct  = 0;
   int items_sent = 0;
   int settings   = 1;

   raycast_wall_texel_mapper DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_texel(rsp_tdata, rsp_tlast);
   end

   // hold each item until accepted; idle between items at the configured rate
   task automatic send_item(input wall_item_t it);
      @(negedge clock);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.cmd;
      req_tdata  <= {7'd0, it.row_y, it.column_x, it.end_row, it.line_height, it.wall_dist,
                     it.viewer_y, it.viewer_x, it.dir_y, it.dir_x, it.side};
      do @(posedge clock); while (!req_tready);
      sb.log_request(it);
      items_sent++;
   endtask

   task automatic write_size(input logic [2:0] idx, input logic [10:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_size(idx, value);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      csr_valid  <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      // a trailing column item gives no result but may still be in flight
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   function automatic wall_item_t random_item();
      wall_item_t   it;
      logic [159:0] raw;
      raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      it = raw[157:0];
      return it;
   endfunction

   function automatic wall_item_t row_item(input logic [8:0] y);
      wall_item_t it;
      it = random_item();
      it.cmd = CMD_ROW;
      it.row_y = y;
      return it;
   endfunction

   function automatic wall_item_t column_item(input logic side, input logic [17:0] dx,
         input logic [17:0] dy, input logic [23:0] vx, input logic [23:0] vy,
         input logic [23:0] wall_len, input logic [14:0] lh, input logic [9:0] stop,
         input logic [9:0] col);
      wall_item_t it;
      it = random_item();
      it.cmd = CMD_COLUMN;
      it.side = side;
      it.dir_x = dx;
      it.dir_y = dy;
      it.viewer_x = vx;
      it.viewer_y = vy;
      it.wall_dist = wall_len;
      it.line_height = lh;
      it.end_row = stop;
      it.column_x = col;
      return it;
   endfunction

   // one column setup followed by a short run of rows inside its slice
   task automatic send_slice();
      wall_item_t it;
      int lh, top, bottom, n, y;
      it = random_item();
      it.cmd = CMD_COLUMN;
      case ($urandom_range(0, 9))
         0: it.dir_x = '0;
         1: it.dir_y = '0;
         default: ;
      endcase
      if ($urandom_range(0, 3) == 0) it.wall_dist = 24'($urandom_range(0, 24'h3FFFF));
      n = $urandom_range(0, 19);
      if (n == 0) lh = 0;
      else if (n < 5) lh = $urandom_range(1, 32767);
      else lh = $urandom_range(1, 700);
      top = SCREEN_H / 2 - lh / 2;
      if (top < 0) top = 0;
      bottom = SCREEN_H / 2 + lh / 2;
      if (bottom > SCREEN_H) bottom = SCREEN_H;
      if (bottom <= top) bottom = top + 1;
      it.line_height = 15'(lh);
      it.end_row = 10'(bottom);
      send_item(it);
      n = $urandom_range(1, 6);
      if ($urandom_range(0, 2) != 0)
         y = (bottom - n > top) ? bottom - n : top;
      else
         y = $urandom_range(top, bottom - 1);
      for (int k = 0; k < n && y < bottom; k++) begin
         send_item(row_item(9'(y)));
         y += ($urandom_range(0, 3) == 0) ? $urandom_range(2, 8) : 1;
      end
   endtask

   function automatic logic [10:0] size_for(input int phase);
      case (phase)
         0: return 11'd1024;
         1: return 11'd0;
         2: return 11'h7FF;
         3: return 11'd1;
         4: return 11'($urandom_range(1, 16));
         5: return 11'($urandom_range(0, 2047));
         default: return 11'($urandom_range(1, 1024));
      endcase
   endfunction

   initial begin
      int target;
      sb = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset state, every facing, field extremes, clamps and edges
      send_item(row_item(9'd0));
      send_item(column_item(1'b0, 18'h1FFFF, 18'h20000, 24'hFFFFFF, 24'hFFFFFF,
                            24'hFFFFFF, 15'd0, 10'd1023, 10'd1023));
      send_item(row_item(9'd511));
      send_item(row_item(9'd0));
      send_item(column_item(1'b0, 18'h20000, 18'h1FFFF, 24'h0, 24'h0,
                            24'hFFFFFF, 15'd32767, 10'd512, 10'd0));
      send_item(row_item(9'd511));
      send_item(row_item(9'd256));
      // zero x direction on a vertical hit falls to north; negative hit sum
      send_item(column_item(1'b0, 18'h0, 18'h3FFFF, 24'h0, 24'h0,
                            24'h1, 15'd512, 10'd512, 10'd517));
      send_item(row_item(9'd0));
      send_item(row_item(9'd255));
      send_item(column_item(1'b1, 18'h20000, 18'h00001, 24'h0, 24'h123456,
                            24'h100000, 15'd1, 10'd0, 10'd300));
      send_item(row_item(9'd256));
      send_item(row_item(9'd255));
      send_item(column_item(1'b1, 18'h1FFFF, 18'h3FFFF, 24'hFFFFFF, 24'h0,
                            24'hFFFFFF, 15'd300, 10'd406, 10'd682));
      send_item(row_item(9'd405));
      send_item(row_item(9'd106));
      send_item(column_item(1'b1, 18'h15555, 18'h0, 24'hAAAAAA, 24'h555555,
                            24'h2AAAAA, 15'd700, 10'd0, 10'd341));
      send_item(row_item(9'd511));
      drain();

      for (int p = 0; p < PHASES; p++) begin
         for (int i = 0; i < 8; i++) write_size(3'(i), size_for(p));
         drain();
         settings++;
         case (p % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 71; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 71; end
            default: begin gap_pct = 21; stall_pct = 21; end
         endcase
         target = items_sent + PHASE_ITEMS;
         // first row reads the previous column under the new sizes
         send_item(row_item(9'($urandom_range(0, 511))));
         while (items_sent < target) begin
            if ($urandom_range(0, 99) < 15) send_item(random_item());
            else send_slice();
         end
         drain();
      end

      $display("Run covered %0d column and %0d row items under %0d texture size settings,",
               sb.columns, sb.rows, settings);
      $display("with sender gaps and receiver stalls; %0d texels checked, %0d mismatches.",
               sb.checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d texels still expected", sb.pending());
      $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> files.f
rtl/rwtm_pkg.sv
rtl/rwtm_div.sv
rtl/raycast_wall_texel_mapper.sv
rtl/rwtm_checker.sv
sim/tb_raycast_wall_texel_mapper.sv
